### rtl/core/assert_macros.svh
// Assertion macros used by the quicksort engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, checked while reset is released.
`define QSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked implication, checked while reset is released.
`define QSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define QSE_ASSERT(label, clk, rstn, prop, msg)
`define QSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/core/qse_pkg.sv
// Types and sequencer states of the quicksort engine.
package qse_pkg;

    // Input transfer payload
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } qse_in_t;

    // Result transfer payload
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } qse_out_t;

    // Sequencer request to load the output register
    typedef struct packed {
        logic load;
        logic final_res;
        logic overflow;
    } qse_emit_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_POP_RD,
        S_PIV_RD,
        S_CMP,
        S_SWAP_A,
        S_SWAP_B,
        S_FIN_A,
        S_FIN_B,
        S_PUSH_R,
        S_PUSH_L,
        S_EM_RD,
        S_EM_LD
    } qse_state_t;

endpackage

### rtl/core/qse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/qse_cmp.sv
// Shared signed compare unit of the partition loop.
module qse_cmp (
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               less
);

    // Flag a strictly below b, two's complement
    always_comb begin
        less = (a < b);
    end

endmodule

### rtl/core/qse_seq.sv
// Sequencer of the quicksort engine: load, partition, range stack and emit control.
`include "assert_macros.svh"

module qse_seq #(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  qse_pkg::qse_in_t    s_data,
    output logic                s_ready,
    input  logic                out_valid,
    input  logic                m_ready,
    input  logic [31:0]         store_rdata,
    output logic                store_we,
    output logic [IW-1:0]       store_waddr,
    output logic [31:0]         store_wdata,
    output logic [IW-1:0]       store_raddr,
    input  logic [2*IW-1:0]     stk_rdata,
    output logic                stk_we,
    output logic [IW-1:0]       stk_waddr,
    output logic [2*IW-1:0]     stk_wdata,
    output logic [IW-1:0]       stk_raddr,
    input  logic                less,
    output logic [31:0]         cmp_a,
    output logic [31:0]         cmp_b,
    output qse_pkg::qse_emit_t  emit
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    qse_pkg::qse_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] place_reg, place_next;
    logic [IW-1:0] k_reg, k_next;
    logic [31:0]   pivot_reg, pivot_next;
    logic [31:0]   valj_reg, valj_next;

    logic          in_xfer;
    logic          room;
    logic [IW-1:0] stk_lo, stk_hi;
    logic [IW-1:0] j_inc, place_inc, place_dec;
    logic [CW-1:0] sp_dec, count_dec;
    logic          j_end;
    logic          push_r_ok, push_l_ok;
    logic          out_free;
    logic          last_k;

    // Shared terms
    always_comb begin
        in_xfer   = s_valid && s_ready;
        room      = (count_reg < DEPTH_C);
        stk_lo    = stk_rdata[2*IW-1:IW];
        stk_hi    = stk_rdata[IW-1:0];
        j_inc     = j_reg + IW'(1);
        place_inc = place_reg + IW'(1);
        place_dec = place_reg - IW'(1);
        sp_dec    = sp_reg - CW'(1);
        count_dec = count_reg - CW'(1);
        j_end     = (j_inc == hi_reg);
        push_r_ok = (({1'b0, place_reg} + (IW+1)'(1)) < {1'b0, hi_reg})
                    && (sp_reg < DEPTH_C);
        push_l_ok = ({1'b0, place_reg} > ({1'b0, lo_reg} + (IW+1)'(1)))
                    && (sp_reg < DEPTH_C);
        out_free  = !out_valid || m_ready;
        last_k    = (CW'(k_reg) == count_dec);
        cmp_a     = store_rdata;
        cmp_b     = pivot_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qse_pkg::S_LOAD: begin
                if (in_xfer && s_data.last) begin
                    state_next = qse_pkg::S_INIT;
                end
            end
            qse_pkg::S_INIT:   state_next = qse_pkg::S_POP;
            qse_pkg::S_POP: begin
                state_next = (sp_reg == '0) ? qse_pkg::S_EM_RD : qse_pkg::S_POP_RD;
            end
            qse_pkg::S_POP_RD: begin
                state_next = (stk_lo >= stk_hi) ? qse_pkg::S_POP : qse_pkg::S_PIV_RD;
            end
            qse_pkg::S_PIV_RD: state_next = qse_pkg::S_CMP;
            qse_pkg::S_CMP: begin
                if (less) begin
                    state_next = qse_pkg::S_SWAP_A;
                end else if (j_end) begin
                    state_next = qse_pkg::S_FIN_A;
                end
            end
            qse_pkg::S_SWAP_A: state_next = qse_pkg::S_SWAP_B;
            qse_pkg::S_SWAP_B: begin
                state_next = j_end ? qse_pkg::S_FIN_A : qse_pkg::S_CMP;
            end
            qse_pkg::S_FIN_A:  state_next = qse_pkg::S_FIN_B;
            qse_pkg::S_FIN_B:  state_next = qse_pkg::S_PUSH_R;
            qse_pkg::S_PUSH_R: state_next = qse_pkg::S_PUSH_L;
            qse_pkg::S_PUSH_L: state_next = qse_pkg::S_POP;
            qse_pkg::S_EM_RD: begin
                if (out_free) begin
                    state_next = qse_pkg::S_EM_LD;
                end
            end
            qse_pkg::S_EM_LD: begin
                state_next = last_k ? qse_pkg::S_LOAD : qse_pkg::S_EM_RD;
            end
            default: state_next = qse_pkg::S_LOAD;
        endcase
    end

    // Memory ports, handshake and emit requests
    always_comb begin
        s_ready        = (state_reg == qse_pkg::S_LOAD);
        store_we       = 1'b0;
        store_waddr    = j_reg;
        store_wdata    = store_rdata;
        store_raddr    = j_reg;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[IW-1:0];
        stk_wdata      = {place_inc, hi_reg};
        stk_raddr      = sp_dec[IW-1:0];
        emit.load      = 1'b0;
        emit.final_res = last_k;
        emit.overflow  = dropped_reg;
        case (state_reg)
            qse_pkg::S_LOAD: begin
                store_we    = in_xfer && room;
                store_waddr = count_reg[IW-1:0];
                store_wdata = s_data.value;
            end
            qse_pkg::S_INIT: begin
                stk_we    = (count_reg >= TWO_C);
                stk_waddr = '0;
                stk_wdata = {{IW{1'b0}}, count_dec[IW-1:0]};
            end
            qse_pkg::S_POP_RD: store_raddr = stk_hi;
            qse_pkg::S_PIV_RD: store_raddr = lo_reg;
            qse_pkg::S_CMP: begin
                store_raddr = (less || j_end) ? place_reg : j_inc;
            end
            qse_pkg::S_SWAP_A: begin
                store_we    = 1'b1;
                store_waddr = j_reg;
                store_wdata = store_rdata;
            end
            qse_pkg::S_SWAP_B: begin
                store_we    = 1'b1;
                store_waddr = place_reg;
                store_wdata = valj_reg;
                store_raddr = j_end ? place_inc : j_inc;
            end
            qse_pkg::S_FIN_A: begin
                store_we    = 1'b1;
                store_waddr = hi_reg;
                store_wdata = store_rdata;
            end
            qse_pkg::S_FIN_B: begin
                store_we    = 1'b1;
                store_waddr = place_reg;
                store_wdata = pivot_reg;
            end
            qse_pkg::S_PUSH_R: begin
                stk_we    = push_r_ok;
                stk_wdata = {place_inc, hi_reg};
            end
            qse_pkg::S_PUSH_L: begin
                stk_we    = push_l_ok;
                stk_wdata = {lo_reg, place_dec};
            end
            qse_pkg::S_EM_RD:  store_raddr = k_reg;
            qse_pkg::S_EM_LD:  emit.load = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Counters, indexes and held values
    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        sp_next      = sp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        place_next   = place_reg;
        k_next       = k_reg;
        pivot_next   = pivot_reg;
        valj_next    = valj_reg;
        case (state_reg)
            qse_pkg::S_LOAD: begin
                if (in_xfer) begin
                    if (room) begin
                        count_next = count_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            qse_pkg::S_INIT: begin
                if (count_reg >= TWO_C) begin
                    sp_next = CW'(1);
                end
            end
            qse_pkg::S_POP: begin
                if (sp_reg == '0) begin
                    k_next = '0;
                end else begin
                    sp_next = sp_dec;
                end
            end
            qse_pkg::S_POP_RD: begin
                lo_next = stk_lo;
                hi_next = stk_hi;
            end
            qse_pkg::S_PIV_RD: begin
                pivot_next = store_rdata;
                j_next     = lo_reg;
                place_next = lo_reg;
            end
            qse_pkg::S_CMP: begin
                valj_next = store_rdata;
                if (!less) begin
                    j_next = j_inc;
                end
            end
            qse_pkg::S_SWAP_B: begin
                j_next     = j_inc;
                place_next = place_inc;
            end
            qse_pkg::S_PUSH_R: begin
                if (push_r_ok) begin
                    sp_next = sp_reg + CW'(1);
                end
            end
            qse_pkg::S_PUSH_L: begin
                if (push_l_ok) begin
                    sp_next = sp_reg + CW'(1);
                end
            end
            qse_pkg::S_EM_LD: begin
                if (last_k) begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    sp_next      = '0;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qse_pkg::S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sp_reg      <= sp_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        place_reg <= place_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        valj_reg  <= valj_next;
    end

    `QSE_ASSERT(a_sp_bound, aclk, aresetn, sp_reg <= DEPTH_C, "range stack overrun")
    `QSE_ASSERT(a_count_bound, aclk, aresetn, count_reg <= DEPTH_C, "element count overrun")
    `QSE_ASSERT_IMP(a_scan_order, aclk, aresetn, state_reg == qse_pkg::S_CMP, (place_reg <= j_reg) && (j_reg < hi_reg), "partition indexes out of order")
    `QSE_ASSERT_IMP(a_emit_free, aclk, aresetn, emit.load, !out_valid, "output register overwritten")

endmodule

### rtl/core/quicksort_engine_unit.sv
// Input: one input transfer per cycle while loading; the closing transfer starts the sort,
// and s_ready stays low until the last result of the set is loaded into the output register.
// Sort: each popped range passes the stack read, pivot read and a compare scan with swaps,
// then the pivot placement and up to two range pushes; a range too short to split is dropped.
// Emit: each result is read through the element store read port, then loaded once the output register is free.
// Reset: synchronous, active low; clears sequencer state, counters and output valid only, no clearing pass.
module quicksort_engine_unit #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qse_pkg::qse_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qse_pkg::qse_out_t   m_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic               store_we;
    logic [IW-1:0]      store_waddr;
    logic [31:0]        store_wdata;
    logic [IW-1:0]      store_raddr;
    logic [31:0]        store_rdata;
    logic               stk_we;
    logic [IW-1:0]      stk_waddr;
    logic [2*IW-1:0]    stk_wdata;
    logic [IW-1:0]      stk_raddr;
    logic [2*IW-1:0]    stk_rdata;
    logic [31:0]        cmp_a, cmp_b;
    logic               less;
    qse_pkg::qse_emit_t emit;

    logic               out_valid_reg, out_valid_next;
    qse_pkg::qse_out_t  out_reg, out_next;

    // Element store
    qse_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(store_waddr),
        .wdata(store_wdata),
        .raddr(store_raddr),
        .rdata(store_rdata)
    );

    // Range stack, lo in the upper half and hi in the lower half
    qse_ram #(
        .WIDTH(2 * IW),
        .DEPTH(DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    qse_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .less(less)
    );

    qse_seq #(
        .DEPTH(DEPTH),
        .IW   (IW),
        .CW   (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .s_ready    (s_ready),
        .out_valid  (out_valid_reg),
        .m_ready    (m_ready),
        .store_rdata(store_rdata),
        .store_we   (store_we),
        .store_waddr(store_waddr),
        .store_wdata(store_wdata),
        .store_raddr(store_raddr),
        .stk_rdata  (stk_rdata),
        .stk_we     (stk_we),
        .stk_waddr  (stk_waddr),
        .stk_wdata  (stk_wdata),
        .stk_raddr  (stk_raddr),
        .less       (less),
        .cmp_a      (cmp_a),
        .cmp_b      (cmp_b),
        .emit       (emit)
    );

    // Output register: load on emit request, drop valid after the transfer
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit.load) begin
            out_next.sorted_value = store_rdata;
            out_next.final_res    = emit.final_res;
            out_next.overflow     = emit.overflow;
            out_valid_next        = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
